### hdl/dbas_pkg.sv
package dbas_pkg;

  localparam int unsigned FluxW   = 24;
  localparam int unsigned TauW    = 24;
  localparam int unsigned MuW     = 17;
  localparam int unsigned TransW  = 17;
  localparam int unsigned DvdW    = 40;
  localparam int unsigned DsrW    = 17;
  localparam int unsigned CntW    = 6;
  localparam int unsigned MulAW   = 33;
  localparam int unsigned MulBW   = 32;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned SumW    = 36;

  localparam logic [FluxW-1:0]  FluxMax   = '1;
  localparam logic [31:0]       ExpM1Q32  = 32'd1580030169;
  localparam logic [3:0]        LastTerm  = 4'd13;
  localparam logic [3:0]        IntLimit  = 4'd12;
  localparam logic [TransW-1:0] OneQ16    = 17'd65536;
  localparam logic [CntW-1:0]   DivSteps  = 6'd40;

  typedef enum logic [1:0] {
    MUL_TOP  = 2'd0,
    MUL_SER  = 2'd1,
    MUL_EXP  = 2'd2,
    MUL_FLUX = 2'd3
  } mul_sel_t;

  typedef enum logic {
    DIV_RATIO = 1'b0,
    DIV_TERM  = 1'b1
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_start;
    div_sel_t div_sel;
    logic     x_capture;
    logic     t_clear;
    logic     ser_acc;
    logic     s_load;
    logic     exp_acc;
    logic     trans;
    logic     top_push;
    logic     layer_push;
  } dbas_cmd_t;

  typedef struct packed {
    logic mu0_zero;
    logic div_busy;
    logic div_done;
    logic x_big;
    logic k_last;
    logic i_zero;
    logic out_free;
  } dbas_status_t;

endpackage

### hdl/dbas_ifs.sv
interface dbas_in_if;
  import dbas_pkg::*;
  logic              valid;
  logic              ready;
  logic              start_column;
  logic [FluxW-1:0]  incident_flux;
  logic [TauW-1:0]   optical_depth;
  logic [MuW-1:0]    cos_zenith;

  modport source (output valid, start_column, incident_flux, optical_depth, cos_zenith,
                  input ready);
  modport sink (input valid, start_column, incident_flux, optical_depth, cos_zenith,
                output ready);
endinterface

interface dbas_out_if;
  import dbas_pkg::*;
  logic             valid;
  logic             ready;
  logic [FluxW-1:0] flux;
  logic             is_top_level;
  logic             last_of_item;

  modport source (output valid, flux, is_top_level, last_of_item, input ready);
  modport sink (input valid, flux, is_top_level, last_of_item, output ready);
endinterface

### hdl/direct_beam_attenuation_sweep_core.sv
// Direct beam attenuation sweep.
// in_ch takes one beat per atmospheric layer, top to surface; start_column
// marks a column's top layer and brings in its incident flux. out_ch gives
// the top-of-atmosphere flux first on such a beat, then one layer flux per
// beat (last_of_item set on it).
// One item is worked at a time; in_ch.ready is high only between items.
// The one-bit-per-cycle 40-step divider is shared by the tau/mu0 ratio and
// the twelve series terms. The series is skipped when mu0 is zero or when
// tau/mu0 reaches 12; otherwise the exponent step runs once per whole unit
// of tau/mu0 (at most 11).
// Results sit in an output register; a stalled receiver holds the block in
// its emit step until the beat is taken, nothing is dropped.
// Synchronous reset clears the carried flux to zero, empties the output
// register and returns the controller to idle.
module direct_beam_attenuation_sweep_core (
  input  logic        clk,
  input  logic        rst_n,
  dbas_in_if.sink     in_ch,
  dbas_out_if.source  out_ch
);
  import dbas_pkg::*;

  dbas_cmd_t    cmd;
  dbas_status_t status;
  logic         in_ready;

  dbas_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_start_column (in_ch.start_column),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .status          (status)
  );

  dbas_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_incident_flux (in_ch.incident_flux),
    .in_optical_depth (in_ch.optical_depth),
    .in_cos_zenith    (in_ch.cos_zenith),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_flux         (out_ch.flux),
    .out_is_top_level (out_ch.is_top_level),
    .out_last_of_item (out_ch.last_of_item)
  );

  assign in_ch.ready = in_ready;
endmodule

### hdl/dbas_div.sv
module dbas_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dbas_pkg::DvdW-1:0]   dividend,
  input  logic [dbas_pkg::DsrW-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [dbas_pkg::DvdW-1:0]   quotient
);
  import dbas_pkg::*;

  logic [DvdW-1:0] q_r, q_nxt;
  logic [DsrW-1:0] rem_r, rem_nxt, dsr_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [DsrW+1:0] diff;
  logic            ge;

  // trial subtract of one quotient bit
  assign diff = {1'b0, rem_r, q_r[DvdW-1]} - {2'b00, dsr_r};
  assign ge   = ~diff[DsrW+1];

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = DivSteps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DsrW-1:0] : {rem_r[DsrW-2:0], q_r[DvdW-1]};
      q_nxt   = {q_r[DvdW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dsr_r <= divisor;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;
endmodule

### hdl/dbas_datapath.sv
module dbas_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dbas_pkg::dbas_cmd_t           cmd,
  output dbas_pkg::dbas_status_t        status,
  input  logic [dbas_pkg::FluxW-1:0]    in_incident_flux,
  input  logic [dbas_pkg::TauW-1:0]     in_optical_depth,
  input  logic [dbas_pkg::MuW-1:0]      in_cos_zenith,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dbas_pkg::FluxW-1:0]    out_flux,
  output logic                          out_is_top_level,
  output logic                          out_last_of_item
);
  import dbas_pkg::*;

  logic [FluxW-1:0]  inc_r, carried_r, out_flux_r;
  logic [TauW-1:0]   tau_r;
  logic [MuW-1:0]    mu0_r;
  logic [31:0]       fq_r, term_r;
  logic [SumW-1:0]   sum_r;
  logic [3:0]        k_r, i_r;
  logic [MulAW-1:0]  s_r;
  logic [TransW-1:0] t_r;
  logic [ProdW-1:0]  prod_r;
  logic              out_valid_r, out_top_r, out_last_r;

  logic [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]  mul_b;
  logic [ProdW-1:0]  rnd16, rnd32;
  logic [FluxW-1:0]  flux_sat;
  logic [DvdW-1:0]   div_dvd, div_q;
  logic [DsrW-1:0]   div_dsr;
  logic              div_busy, div_done;
  logic [SumW-1:0]   term_ext;
  logic [MulAW:0]    s_rnd;
  logic [17:0]       t_raw;

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_TOP:  begin mul_a = {9'b0, inc_r};     mul_b = {15'b0, mu0_r}; end
      MUL_SER:  begin mul_a = {1'b0, term_r};    mul_b = fq_r;           end
      MUL_EXP:  begin mul_a = s_r;               mul_b = ExpM1Q32;       end
      MUL_FLUX: begin mul_a = {9'b0, carried_r}; mul_b = {15'b0, t_r};   end
      default:  begin mul_a = '0;                mul_b = '0;             end
    endcase
  end

  // round the product to Q12.12 and saturate
  assign rnd16    = prod_r + ProdW'(17'h08000);
  assign flux_sat = (|rnd16[ProdW-1:40]) ? FluxMax : rnd16[39:16];
  assign rnd32    = prod_r + ProdW'(33'h080000000);

  // divider operands
  assign div_dvd = (cmd.div_sel == DIV_RATIO) ? {tau_r, 16'b0} : {8'b0, prod_r[63:32]};
  assign div_dsr = (cmd.div_sel == DIV_RATIO) ? mu0_r : {13'b0, k_r};

  dbas_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign term_ext = {4'b0, div_q[31:0]};
  assign s_rnd    = {1'b0, s_r} + (MulAW+1)'(16'h8000);
  assign t_raw    = s_rnd[MulAW:16];

  // capture item and run the product, series, exponent, transmission and output registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inc_r <= in_incident_flux;
      tau_r <= in_optical_depth;
      mu0_r <= in_cos_zenith;
    end
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
    if (cmd.x_capture) begin
      i_r    <= div_q[19:16];
      fq_r   <= {div_q[15:0], 16'b0};
      term_r <= {div_q[15:0], 16'b0};
      sum_r  <= SumW'(36'h100000000) - {4'b0, div_q[15:0], 16'b0};
      k_r    <= 4'd2;
    end else if (cmd.ser_acc) begin
      term_r <= div_q[31:0];
      sum_r  <= k_r[0] ? sum_r - term_ext : sum_r + term_ext;
      k_r    <= k_r + 1'b1;
    end
    if (cmd.s_load) begin
      if (sum_r[SumW-1])                      s_r <= '0;
      else if (sum_r > SumW'(36'h100000000))  s_r <= 33'h100000000;
      else                                    s_r <= sum_r[MulAW-1:0];
    end else if (cmd.exp_acc) begin
      s_r <= rnd32[ProdW-1:32];
      i_r <= i_r - 1'b1;
    end
    if (cmd.t_clear)    t_r <= '0;
    else if (cmd.trans) t_r <= (t_raw > {1'b0, OneQ16}) ? OneQ16 : t_raw[TransW-1:0];
    if (cmd.top_push || cmd.layer_push) begin
      out_flux_r <= flux_sat;
      out_top_r  <= cmd.top_push;
      out_last_r <= cmd.layer_push;
    end
  end

  // carried flux and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carried_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.top_push || cmd.layer_push) carried_r <= flux_sat;
      if (cmd.top_push || cmd.layer_push) out_valid_r <= 1'b1;
      else if (out_ready)                 out_valid_r <= 1'b0;
    end
  end

  assign status.mu0_zero = (mu0_r == '0);
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;
  assign status.x_big    = (|div_q[DvdW-1:20]) || (div_q[19:16] >= IntLimit);
  assign status.k_last   = (k_r == LastTerm);
  assign status.i_zero   = (i_r == '0);
  assign status.out_free = ~out_valid_r | out_ready;

  assign out_valid        = out_valid_r;
  assign out_flux         = out_flux_r;
  assign out_is_top_level = out_top_r;
  assign out_last_of_item = out_last_r;
endmodule

### hdl/dbas_ctrl.sv
module dbas_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_start_column,
  output logic                    in_ready,
  output dbas_pkg::dbas_cmd_t     cmd,
  input  dbas_pkg::dbas_status_t  status
);
  import dbas_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE       = 15'b000000000000001,
    ST_TOP_MUL    = 15'b000000000000010,
    ST_TOP_EMIT   = 15'b000000000000100,
    ST_DIV_GO     = 15'b000000000001000,
    ST_DIV_WAIT   = 15'b000000000010000,
    ST_SER_MUL    = 15'b000000000100000,
    ST_SER_DIV_GO = 15'b000000001000000,
    ST_SER_WAIT   = 15'b000000010000000,
    ST_SER_END    = 15'b000000100000000,
    ST_EXP_CHK    = 15'b000001000000000,
    ST_EXP_MUL    = 15'b000010000000000,
    ST_EXP_ACC    = 15'b000100000000000,
    ST_TRANS      = 15'b001000000000000,
    ST_FLUX_MUL   = 15'b010000000000000,
    ST_LAYER_EMIT = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  // sequence one item through the shared units
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_start_column ? ST_TOP_MUL : ST_DIV_GO;
        end
      end
      ST_TOP_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TOP;
        state_nxt   = ST_TOP_EMIT;
      end
      ST_TOP_EMIT: begin
        if (status.out_free) begin
          cmd.top_push = 1'b1;
          state_nxt    = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        if (status.mu0_zero) begin
          cmd.t_clear = 1'b1;
          state_nxt   = ST_FLUX_MUL;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_RATIO;
          state_nxt     = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.x_capture = 1'b1;
          if (status.x_big) begin
            cmd.t_clear = 1'b1;
            state_nxt   = ST_FLUX_MUL;
          end else begin
            state_nxt = ST_SER_MUL;
          end
        end
      end
      ST_SER_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SER;
        state_nxt   = ST_SER_DIV_GO;
      end
      ST_SER_DIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_TERM;
        state_nxt     = ST_SER_WAIT;
      end
      ST_SER_WAIT: begin
        if (status.div_done) begin
          cmd.ser_acc = 1'b1;
          state_nxt   = status.k_last ? ST_SER_END : ST_SER_MUL;
        end
      end
      ST_SER_END: begin
        cmd.s_load = 1'b1;
        state_nxt  = ST_EXP_CHK;
      end
      ST_EXP_CHK: begin
        state_nxt = status.i_zero ? ST_TRANS : ST_EXP_MUL;
      end
      ST_EXP_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_EXP;
        state_nxt   = ST_EXP_ACC;
      end
      ST_EXP_ACC: begin
        cmd.exp_acc = 1'b1;
        state_nxt   = ST_EXP_CHK;
      end
      ST_TRANS: begin
        cmd.trans = 1'b1;
        state_nxt = ST_FLUX_MUL;
      end
      ST_FLUX_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FLUX;
        state_nxt   = ST_LAYER_EMIT;
      end
      ST_LAYER_EMIT: begin
        if (status.out_free) begin
          cmd.layer_push = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == ST_IDLE);

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.top_push || cmd.layer_push) |-> status.out_free)
    else $error("result pushed into a full output register");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !status.div_busy)
    else $error("divider restarted while busy");

  a_top_then_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.top_push |=> (state_r == ST_DIV_GO))
    else $error("top level beat not followed by the layer");
endmodule

### sim/dbas_flux_checker.sv
module dbas_flux_checker (
  input  logic   clk,
  input  logic   rst_n,
  dbas_in_if     in_ch,
  dbas_out_if    out_ch,
  output int     fail_count,
  output int     pending_count,
  output int     beats_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import dbas_pkg::*;

  typedef struct packed {
    logic [FluxW-1:0] flux;
    logic             is_top_level;
    logic             last_of_item;
  } level_flux_t;

  level_flux_t      level_q[$];
  logic [FluxW-1:0] column_flux;

  function automatic logic [FluxW-1:0] clamp_flux(logic [63:0] v);
    return (v > 64'(FluxMax)) ? FluxMax : v[FluxW-1:0];
  endfunction

  // exp(-tau/mu0) in Q1.16, series on the fraction then powers of exp(-1)
  function automatic logic [16:0] beam_transmission(logic [TauW-1:0] tau,
                                                    logic [MuW-1:0] mu0);
    logic [63:0] x, frac, term, s;
    longint      sum;
    int          k;
    if (mu0 == '0) return '0;
    x = ({40'd0, tau} << 16) / {47'd0, mu0};
    if (x >= (64'd12 << 16)) return '0;
    frac = (x & 64'hFFFF) << 16;
    term = 64'd1 << 32;
    sum  = longint'(term);
    for (k = 1; k <= 13; k++) begin
      term = ((term * frac) >> 32) / 64'(k);
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    s = 64'(sum);
    if (s > (64'd1 << 32)) s = 64'd1 << 32;
    for (k = 0; k < int'(x >> 16); k++)
      s = (s * 64'(ExpM1Q32) + (64'd1 << 31)) >> 32;
    s = (s + 64'h8000) >> 16;
    return (s > 64'(OneQ16)) ? OneQ16 : s[16:0];
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    beats_seen = 0;
  end

  assign pending_count = level_q.size();

  always @(posedge clk) begin
    level_flux_t lf, got;
    logic [16:0] trans;
    if (!rst_n) begin
      column_flux = '0;
      level_q.delete();
    end else begin
      // predict on each accepted input beat
      if (in_ch.valid && in_ch.ready) begin
        lf = '0;
        if (in_ch.start_column) begin
          column_flux = clamp_flux((64'(in_ch.incident_flux) * 64'(in_ch.cos_zenith)
                                    + 64'h8000) >> 16);
          lf.flux = column_flux;
          lf.is_top_level = 1'b1;
          level_q.push_back(lf);
        end
        trans = beam_transmission(in_ch.optical_depth, in_ch.cos_zenith);
        column_flux = clamp_flux((64'(column_flux) * 64'(trans) + 64'h8000) >> 16);
        lf.flux = column_flux;
        lf.is_top_level = 1'b0;
        lf.last_of_item = 1'b1;
        level_q.push_back(lf);
      end
      // compare each result beat with the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        beats_seen++;
        if (level_q.size() == 0) begin
          report("unexpected beat", 32'(out_ch.flux), 0);
        end else begin
          got = level_q.pop_front();
          if (out_ch.flux !== got.flux) report("flux", 32'(out_ch.flux), 32'(got.flux));
          if (out_ch.is_top_level !== got.is_top_level)
            report("is_top_level", 32'(out_ch.is_top_level), 32'(got.is_top_level));
          if (out_ch.last_of_item !== got.last_of_item)
            report("last_of_item", 32'(out_ch.last_of_item), 32'(got.last_of_item));
        end
      end
    end
  end
endmodule

### sim/direct_beam_attenuation_sweep_core_tb.sv
module direct_beam_attenuation_sweep_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dbas_pkg::*;

  localparam int NumRandom = 1830;
  localparam int IdleLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count, beats_seen;
  int   idle_cycles = 0;
  int   layers_sent = 0;
  int   columns_sent = 0;

  dbas_in_if  in_ch();
  dbas_out_if out_ch();

  direct_beam_attenuation_sweep_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  dbas_flux_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_count(pending_count), .beats_seen(beats_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.start_column = 1'b0;
    in_ch.incident_flux = '0;
    in_ch.optical_depth = '0;
    in_ch.cos_zenith = '0;
    out_ch.ready = 1'b0;
  end

  // receiver stall pattern: stretches fully open, lightly stalled and heavily stalled in turn
  always @(posedge clk) begin
    int phase;
    phase = ($realtime > 0) ? int'($realtime / 10) % 3000 : 0;
    if (phase < 800) out_ch.ready <= 1'b1;
    else if (phase < 1800) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= ($urandom_range(0, 4) == 0);
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("direct_beam_attenuation_sweep_core_tb NOT OK");
      $finish;
    end
  end

  // drive one layer beat and hold it until accepted
  task automatic send_layer(logic sc, logic [FluxW-1:0] inc, logic [TauW-1:0] tau,
                            logic [MuW-1:0] mu);
    in_ch.valid <= 1'b1;
    in_ch.start_column <= sc;
    in_ch.incident_flux <= inc;
    in_ch.optical_depth <= tau;
    in_ch.cos_zenith <= mu;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    layers_sent++;
    if (sc) columns_sent++;
  endtask

  task automatic pause_sender(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [MuW-1:0] pick_mu();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 17'd65536;
      2: return MuW'($urandom_range(65537, 131071));
      default: return MuW'($urandom_range(1, 65536));
    endcase
  endfunction

  function automatic logic [TauW-1:0] pick_tau();
    case ($urandom_range(0, 7))
      0: return TauW'($urandom);
      1: return TauW'($urandom_range(0, 255));
      default: return TauW'($urandom_range(0, 1 << 18));
    endcase
  endfunction

  initial begin
    int burst, column_len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // layer before any column, then field extremes and special cases
    send_layer(1'b0, 24'hFFFFFF, 24'd1000, 17'd65536);
    send_layer(1'b1, 24'hFFFFFF, 24'd0, 17'd65536);
    send_layer(1'b0, 24'h0, 24'd0, 17'd65536);
    send_layer(1'b1, 24'hFFFFFF, 24'd0, 17'h1FFFF);
    send_layer(1'b0, 24'h0, 24'd1, 17'd1);
    send_layer(1'b1, 24'h000001, 24'd0, 17'd0);
    send_layer(1'b1, 24'hABCDEF, 24'hFFFFFF, 17'd65536);
    send_layer(1'b1, 24'h800000, 24'd65536, 17'd65536);
    send_layer(1'b0, 24'h555555, 24'd786431, 17'd65536);
    send_layer(1'b0, 24'hAAAAAA, 24'd786432, 17'd65536);
    send_layer(1'b1, 24'h123456, 24'd32768, 17'd32768);
    send_layer(1'b0, 24'h0, 24'hFFFFFF, 17'h1FFFF);
    send_layer(1'b0, 24'h0, 24'd12345, 17'd0);
    pause_sender(3);

    // random columns in bursts with random gaps
    burst = 0;
    while (layers_sent < NumRandom + 13) begin
      column_len = $urandom_range(1, 8);
      for (int l = 0; l < column_len; l++) begin
        send_layer((l == 0) && ($urandom_range(0, 15) != 0), 24'($urandom), pick_tau(),
                   pick_mu());
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
        end else begin
          burst--;
        end
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d layers in %0d columns, checked %0d result beats",
             layers_sent, columns_sent, beats_seen);
    if (fail_count == 0) $display("direct_beam_attenuation_sweep_core_tb OK");
    else $display("direct_beam_attenuation_sweep_core_tb NOT OK");
    $finish;
  end
endmodule

### sim.f
hdl/dbas_pkg.sv
hdl/dbas_ifs.sv
hdl/dbas_div.sv
hdl/dbas_datapath.sv
hdl/dbas_ctrl.sv
hdl/direct_beam_attenuation_sweep_core.sv
sim/dbas_flux_checker.sv
sim/direct_beam_attenuation_sweep_core_tb.sv
